// File: rtl/cwvp_pkg.sv
`default_nettype none

package cwvp_pkg;

  localparam int CWVP_MAX_STEPS = 64;
  localparam int WALK_W         = 64;
  localparam int LEN_W          = 7;
  // Vertex coordinates stay within a few units of the walk length.
  localparam int CRD_W          = 9;
  localparam int TOT_W          = 13;
  localparam int TURN_EXCESS    = 4;

  typedef logic [CRD_W-1:0] crd_t;

  typedef struct packed {
    logic [WALK_W-1:0] walk_bits;
    logic [LEN_W-1:0]  walk_length;
  } cwvp_in_t;

  typedef struct packed {
    logic no_vertex_polygon;
    logic is_clockwise;
    logic turn_count_error;
  } cwvp_out_t;

  typedef struct packed {
    logic load;
    logic step1;
    logic step2;
    logic fin;
  } cwvp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic last_step;
  } cwvp_sts_t;

endpackage

`default_nettype wire

// File: rtl/cwvp_dp.sv
`default_nettype none

module cwvp_dp
  import cwvp_pkg::*;
#(
  parameter int MAX_STEPS = CWVP_MAX_STEPS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cwvp_cmd_t cmd,
  input  wire cwvp_in_t  in_item,
  output cwvp_sts_t      sts,
  output cwvp_out_t      out_item
);

  localparam int IW = $clog2(MAX_STEPS);
  localparam int NW = $clog2(MAX_STEPS + 1);

  localparam crd_t CRD_ONE  = CRD_W'(1);
  localparam crd_t CRD_MONE = {CRD_W{1'b1}};

  function automatic crd_t floor_half(crd_t a, crd_t b);
    logic [CRD_W:0] s;
    s = {a[CRD_W-1], a} + {b[CRD_W-1], b};
    return s[CRD_W:1];
  endfunction

  function automatic crd_t abs_diff(crd_t a, crd_t b);
    logic [CRD_W:0] d;
    d = {a[CRD_W-1], a} - {b[CRD_W-1], b};
    if (d[CRD_W]) begin
      d = ~d + 1'b1;
    end
    return d[CRD_W-1:0];
  endfunction

  logic [MAX_STEPS-1:0] w_r;
  logic [LEN_W-1:0]     len_r;
  logic [IW-1:0]        idx_r, idx_nxt, lidx_r;

  logic                 pv1_r, xs1_r, ys1_r;
  logic [NW-1:0]        lefts_r, rights_r;

  logic                 pv2_r, xs2_r, ys2_r;
  crd_t                 x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  crd_t                 vx_r, vy_r, fx_r, fy_r;
  logic [TOT_W-1:0]     total_r;
  logic                 have_first_r, fail_r;
  cwvp_out_t            res_r;

  logic [LEN_W-1:0]     len_sat;
  logic [IW-1:0]        lidx_in;
  logic                 last_in;

  logic                 st, turn1, right1;
  logic                 cw, err;
  crd_t                 x3n, y3n, vxn, vyn, dx, dy, dxf, dyf;
  logic                 turn2, rt, pair_bad, fin_bad, tgt_ok;
  logic [TOT_W-1:0]     half, half_f, tgt;

  always_comb begin
    len_sat = (in_item.walk_length > LEN_W'(MAX_STEPS)) ? LEN_W'(MAX_STEPS)
                                                       : in_item.walk_length;
    lidx_in = IW'(len_sat - LEN_W'(1));
    last_in = (len_sat != '0) && in_item.walk_bits[lidx_in];
  end

  always_comb begin
    st     = w_r[idx_r];
    turn1  = (pv1_r != st);
    right1 = pv1_r ^ xs1_r ^ ys1_r;

    cw  = ({1'b0, rights_r} == {1'b0, lefts_r} + (NW+1)'(TURN_EXCESS));
    err = !cw && ({1'b0, lefts_r} != {1'b0, rights_r} + (NW+1)'(TURN_EXCESS));

    x3n   = st ? x3_r : x3_r + (xs2_r ? CRD_ONE : CRD_MONE);
    y3n   = st ? y3_r + (ys2_r ? CRD_ONE : CRD_MONE) : y3_r;
    turn2 = (pv2_r != st);
    // Turn direction from the parity of the corner point.
    rt    = pv2_r ^ x2_r[0] ^ y2_r[0];
    vxn   = floor_half(x1_r, x3n);
    vyn   = floor_half(y1_r, y3n);
    if (rt != cw) begin
      vxn = vxn - ((x1_r - x2_r) + (x3n - x2_r));
      vyn = vyn - ((y1_r - y2_r) + (y3n - y2_r));
    end
    dx       = abs_diff(vxn, vx_r);
    dy       = abs_diff(vyn, vy_r);
    pair_bad = ((dx != '0) && (dy != '0)) || (dx[0] ^ dy[0]);
    half     = TOT_W'((dx | dy) >> 1);

    dxf     = abs_diff(fx_r, vx_r);
    dyf     = abs_diff(fy_r, vy_r);
    half_f  = TOT_W'((dxf | dyf) >> 1);
    // (length - 4) / 2 truncates toward zero, so length three still targets zero.
    tgt_ok  = (len_r >= LEN_W'(TURN_EXCESS - 1));
    tgt     = (len_r >= LEN_W'(TURN_EXCESS)) ?
              TOT_W'((len_r - LEN_W'(TURN_EXCESS)) >> 1) : '0;
    fin_bad = fail_r || !have_first_r ||
              ((dxf != '0) && (dyf != '0)) || (dxf[0] ^ dyf[0]) ||
              !tgt_ok || ((total_r + half_f) != tgt);
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.step1 || cmd.step2) begin
      idx_nxt = sts.last_step ? '0 : idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r          <= in_item.walk_bits[MAX_STEPS-1:0];
      len_r        <= len_sat;
      lidx_r       <= lidx_in;
      pv1_r        <= last_in;
      xs1_r        <= 1'b1;
      ys1_r        <= 1'b1;
      lefts_r      <= '0;
      rights_r     <= '0;
      pv2_r        <= last_in;
      xs2_r        <= 1'b1;
      ys2_r        <= 1'b1;
      x1_r         <= last_in ? '0 : CRD_MONE;
      y1_r         <= last_in ? CRD_MONE : '0;
      x2_r         <= '0;
      y2_r         <= '0;
      x3_r         <= '0;
      y3_r         <= '0;
      vx_r         <= '0;
      vy_r         <= '0;
      fx_r         <= '0;
      fy_r         <= '0;
      total_r      <= '0;
      have_first_r <= 1'b0;
      fail_r       <= 1'b0;
    end
    if (cmd.step1) begin
      if (turn1 && right1) begin
        rights_r <= rights_r + NW'(1);
      end
      if (turn1 && !right1) begin
        lefts_r <= lefts_r + NW'(1);
      end
      if (st) begin
        xs1_r <= !xs1_r;
      end else begin
        ys1_r <= !ys1_r;
      end
      pv1_r <= st;
    end
    if (cmd.step2) begin
      if (turn2) begin
        vx_r <= vxn;
        vy_r <= vyn;
        if (!have_first_r) begin
          have_first_r <= 1'b1;
          fx_r         <= vxn;
          fy_r         <= vyn;
        end else if (pair_bad) begin
          fail_r <= 1'b1;
        end else begin
          total_r <= total_r + half;
        end
      end
      if (st) begin
        xs2_r <= !xs2_r;
      end else begin
        ys2_r <= !ys2_r;
      end
      x1_r  <= x2_r;
      y1_r  <= y2_r;
      x2_r  <= x3n;
      y2_r  <= y3n;
      x3_r  <= x3n;
      y3_r  <= y3n;
      pv2_r <= st;
    end
    if (cmd.fin) begin
      res_r.no_vertex_polygon <= fin_bad;
      res_r.is_clockwise      <= cw;
      res_r.turn_count_error  <= err;
    end
  end

  assign sts.len_zero  = (len_r == '0);
  assign sts.last_step = (idx_r == lidx_r);
  assign out_item      = res_r;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step1 || cmd.step2) |-> (idx_r <= lidx_r))
    else $error("step index ran past the last step");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step2 && fail_r) |=> fail_r)
    else $error("vertex failure flag cleared during the second pass");

  a_turn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (({1'b0, lefts_r} + {1'b0, rights_r}) <= (NW+1)'(len_r)))
    else $error("more turns counted than steps walked");

endmodule

`default_nettype wire

// File: rtl/cwvp_ctrl.sv
`default_nettype none

module cwvp_ctrl
  import cwvp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  output logic           out_valid,
  output cwvp_cmd_t      cmd,
  input  wire cwvp_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS1,
    S_PASS2,
    S_FINAL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PASS1;
        end
      end
      S_PASS1: begin
        // An empty walk has no steps to count and goes straight to the checks.
        if (sts.len_zero) begin
          state_nxt = S_FINAL;
        end else begin
          cmd.step1 = 1'b1;
          if (sts.last_step) begin
            state_nxt = S_PASS2;
          end
        end
      end
      S_PASS2: begin
        cmd.step2 = 1'b1;
        if (sts.last_step) begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.fin       = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_strobe_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_FINAL))
    else $error("result strobe without a final check cycle");

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_PASS1))
    else $error("accepted transaction did not start the first pass");

  a_empty_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_PASS1) && sts.len_zero) |-> !cmd.step1)
    else $error("empty walk stepped in the first pass");

endmodule

`default_nettype wire

// File: rtl/closed_walk_vertex_polygon_check_unit.sv
// Channel  Ports                      Handshake
// input    in_item (cwvp_in_t)        taken when start is high and busy is low
// result   out_item (cwvp_out_t)      valid for the one cycle out_valid is high
//
// A transaction of N steps (length saturated to MAX_STEPS) walks the bits in two passes,
// one that counts turns and one that places the vertices, one bit per cycle in each,
// followed by the closing checks; an empty walk skips both passes and goes to the checks.
// busy drops in the result cycle, so the next transaction may start then.
// Reset is synchronous and active low; it idles the controller.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none

module closed_walk_vertex_polygon_check_unit
  import cwvp_pkg::*;
#(
  parameter int MAX_STEPS = CWVP_MAX_STEPS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire cwvp_in_t in_item,
  output logic          out_valid,
  output cwvp_out_t     out_item
);

  cwvp_cmd_t cmd;
  cwvp_sts_t sts;

  cwvp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  cwvp_dp #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// File: sim/walk_polygon_checker.sv
`timescale 1ns / 100ps

module walk_polygon_checker
  import cwvp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      busy,
  input  wire cwvp_in_t  in_item,
  input  wire logic      out_valid,
  input  wire cwvp_out_t out_item,
  output int             fail_count,
  output int             pending,
  output int             results_seen,
  output int             polygons_found,
  output int             clockwise_seen
);

  cwvp_out_t verdict_q[$];

  // Inner vertex polygon verdict for one walk, as the block should compute it.
  function automatic cwvp_out_t predict_walk_verdict(cwvp_in_t walk);
    cwvp_out_t r;
    int n, i, xs, ys, lefts, rights;
    int x1, y1, x2, y2, x3, y3;
    int vx, vy, fx, fy, px, py, dx, dy, total;
    bit last, pv, st, cw, err, fail, have_first, rt;
    n = walk.walk_length;
    if (n > CWVP_MAX_STEPS) n = CWVP_MAX_STEPS;
    last = (n > 0) ? walk.walk_bits[n-1] : 1'b0;

    // First pass: count turns, with the last step wrapping around.
    xs = 1; ys = 1; lefts = 0; rights = 0;
    pv = last;
    for (i = 0; i < n; i++) begin
      st = walk.walk_bits[i];
      if (pv != st) begin
        if (pv ^ (xs > 0) ^ (ys > 0)) rights++;
        else lefts++;
      end
      if (st) xs = -xs;
      else ys = -ys;
      pv = st;
    end
    cw  = (rights == lefts + TURN_EXCESS);
    err = (rights != lefts + TURN_EXCESS) && (lefts != rights + TURN_EXCESS);

    // Second pass: place the inner vertices and check consecutive pairs.
    x1 = -1; y1 = 0; x2 = 0; y2 = 0; x3 = 0; y3 = 0;
    if (last) begin
      x1 = 0; y1 = -1;
    end
    xs = 1; ys = 1;
    pv = last;
    vx = 0; vy = 0; fx = 0; fy = 0; total = 0;
    have_first = 1'b0;
    fail = 1'b0;
    for (i = 0; i < n && !fail; i++) begin
      st = walk.walk_bits[i];
      if (st) begin
        y3 += ys; xs = -xs;
      end else begin
        x3 += xs; ys = -ys;
      end
      if (pv != st) begin
        px = vx; py = vy;
        rt = pv ^ (y2[0] == 1'b0) ^ (x2[0] == 1'b0);
        vx = (x1 + x3) >>> 1;
        vy = (y1 + y3) >>> 1;
        // A turn against the orientation puts the vertex on the far side.
        if (rt != cw) begin
          vx -= (x1 - x2) + (x3 - x2);
          vy -= (y1 - y2) + (y3 - y2);
        end
        if (!have_first) begin
          have_first = 1'b1;
          fx = vx; fy = vy;
        end else begin
          dx = (vx > px) ? vx - px : px - vx;
          dy = (vy > py) ? vy - py : py - vy;
          if ((dx != 0 && dy != 0) || ((dx + dy) % 2 != 0)) fail = 1'b1;
          else total += (dx + dy) / 2;
        end
      end
      x1 = x2; y1 = y2; x2 = x3; y2 = y3;
      pv = st;
    end
    if (!fail) begin
      if (!have_first) begin
        fail = 1'b1;
      end else begin
        dx = (fx > vx) ? fx - vx : vx - fx;
        dy = (fy > vy) ? fy - vy : vy - fy;
        if ((dx != 0 && dy != 0) || ((dx + dy) % 2 != 0)) fail = 1'b1;
        else begin
          total += (dx + dy) / 2;
          fail = (total != (n - 4) / 2);
        end
      end
    end
    r.no_vertex_polygon = fail;
    r.is_clockwise      = cw;
    r.turn_count_error  = err;
    return r;
  endfunction

  initial begin
    fail_count     = 0;
    pending        = 0;
    results_seen   = 0;
    polygons_found = 0;
    clockwise_seen = 0;
  end

  // The result is retired before a transaction taken at the same edge is queued.
  always @(posedge clk) begin
    cwvp_out_t want;
    if (rst_n) begin
      if (out_valid) begin
        results_seen++;
        if (!out_item.no_vertex_polygon) polygons_found++;
        if (out_item.is_clockwise) clockwise_seen++;
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no transaction outstanding: nvp=%b cw=%b err=%b",
                     $realtime, out_item.no_vertex_polygon, out_item.is_clockwise,
                     out_item.turn_count_error);
        end else begin
          want = verdict_q.pop_front();
          if (want.no_vertex_polygon !== out_item.no_vertex_polygon ||
              want.is_clockwise !== out_item.is_clockwise ||
              want.turn_count_error !== out_item.turn_count_error) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected nvp=%b cw=%b err=%b, got nvp=%b cw=%b err=%b",
                       $realtime, want.no_vertex_polygon, want.is_clockwise,
                       want.turn_count_error, out_item.no_vertex_polygon,
                       out_item.is_clockwise, out_item.turn_count_error);
          end
        end
      end
      if (start && !busy) verdict_q.insert(verdict_q.size(), predict_walk_verdict(in_item));
      pending = verdict_q.size();
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cwvp_pkg::*;

  localparam int RANDOM_WALKS = 850;
  localparam int CYCLE_LIMIT  = 800000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  cwvp_in_t  in_item;
  logic      out_valid;
  cwvp_out_t out_item;

  int fail_count, pending, results_seen, polygons_found, clockwise_seen;
  int cycle_count;
  int walks_sent;
  int closed_walks_sent;
  bit idle_ok;

  closed_walk_vertex_polygon_check_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  walk_polygon_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_item       (out_item),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .polygons_found (polygons_found),
    .clockwise_seen (clockwise_seen)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Walks on this lattice: consecutive horizontal steps share a direction,
  // and each vertical step reverses the horizontal direction (and vice versa).
  function automatic bit walk_closes(logic [63:0] bits, int n);
    int x, y, xs, ys, i;
    x = 0; y = 0; xs = 1; ys = 1;
    for (i = 0; i < n; i++) begin
      if (bits[i]) begin
        y += ys; xs = -xs;
      end else begin
        x += xs; ys = -ys;
      end
    end
    return n > 0 && x == 0 && y == 0;
  endfunction

  // Rectangle of a horizontal and b vertical steps per side; closes when both are odd.
  function automatic logic [63:0] rectangle_walk(int a, int b);
    logic [63:0] bits;
    int i;
    bits = '0;
    for (i = 0; i < b; i++) begin
      bits[a + i]         = 1'b1;
      bits[2*a + b + i]   = 1'b1;
    end
    return bits;
  endfunction

  task automatic issue_walk(input logic [63:0] bits, input int unsigned n);
    cwvp_in_t t;
    int unsigned gap;
    gap = 0;
    // Long gaps let start rise at any point of the previous transaction.
    if (idle_ok && $urandom_range(99) < 6) gap = $urandom_range(1, 140);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    t.walk_bits   = bits;
    t.walk_length = n[LEN_W-1:0];
    @(negedge clk);
    start   <= 1'b1;
    in_item <= t;
    while (busy) @(negedge clk);
    @(posedge clk);
    walks_sent++;
    if (n <= CWVP_MAX_STEPS && walk_closes(bits, n)) closed_walks_sent++;
  endtask

  initial begin
    logic [63:0] bits;
    int n, a, b, k, tries, mode;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    walks_sent = 0;
    closed_walks_sent = 0;
    idle_ok = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed walks: empty, single step, shortest polygons, saturation, no turns.
    issue_walk(64'h0, 0);
    issue_walk('1, 0);
    issue_walk(64'h0, 1);
    issue_walk(64'h1, 1);
    issue_walk(64'h2, 2);
    issue_walk(64'hA, 4);
    issue_walk(64'h5, 4);
    issue_walk(64'hFFFF_FFFF_FFFF_FFF0 | 64'hA, 4);
    issue_walk(rectangle_walk(3, 1), 8);
    issue_walk(rectangle_walk(1, 3), 8);
    issue_walk(rectangle_walk(3, 3), 12);
    issue_walk(64'h0, 8);
    issue_walk(64'h06, 5);
    issue_walk(64'h0, 64);
    issue_walk('1, 64);
    issue_walk(64'hAAAA_AAAA_AAAA_AAAA, 64);
    issue_walk(64'h5555_5555_5555_5555, 64);
    issue_walk(rectangle_walk(31, 1), 64);
    issue_walk(rectangle_walk(1, 31), 64);
    issue_walk(64'hAAAA_AAAA_AAAA_AAAA, 127);
    issue_walk(rectangle_walk(1, 1) | 64'hF0F0_0000_0000_0000, 65);
    issue_walk(rectangle_walk(15, 17), 96);

    for (k = 0; k < RANDOM_WALKS; k++) begin
      idle_ok = !(k >= 300 && k < 450);
      mode = $urandom_range(99);
      if (mode < 45) begin
        // Random closed walk found by rejection, rectangle if none turns up.
        n = ($urandom_range(9) == 0) ? 2 * $urandom_range(2, 32) : 2 * $urandom_range(2, 10);
        tries = 0;
        do begin
          bits = {$urandom, $urandom};
          tries++;
        end while (!walk_closes(bits, n) && tries < 400);
        if (!walk_closes(bits, n)) begin
          bits = rectangle_walk(1, 1);
          n = 4;
        end
        if ($urandom_range(1) == 0 && n < 64) bits |= {$urandom, $urandom} << n;
      end else if (mode < 70) begin
        a = 2 * $urandom_range(0, 15) + 1;
        b = 2 * $urandom_range(0, (32 - a - 1) / 2) + 1;
        bits = rectangle_walk(a, b);
        n = 2 * (a + b);
        if ($urandom_range(1) == 0 && n < 64) bits |= {$urandom, $urandom} << n;
      end else begin
        bits = {$urandom, $urandom};
        n = $urandom_range(0, 127);
      end
      issue_walk(bits, n);
    end

    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (140) @(posedge clk);

    $display("Sent %0d walks (%0d closed), checked %0d results", walks_sent,
             closed_walks_sent, results_seen);
    $display("Inner polygon found for %0d walks, clockwise in %0d", polygons_found,
             clockwise_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Mismatches: %0d, outstanding: %0d", fail_count, pending);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
